>>> rtl/shp_pkg.sv
// Package for the half-step stepper positioner.
// Function codes, register indexes, coil sequence tables and the result item type.
// No dependencies.
package shp_pkg;

   localparam logic [2:0] FUNC_TICK   = 3'd0;
   localparam logic [2:0] FUNC_MOVE   = 3'd1;
   localparam logic [2:0] FUNC_CENTER = 3'd2;
   localparam logic [2:0] FUNC_QUERY  = 3'd3;
   localparam logic [2:0] FUNC_LOAD   = 3'd4;

   localparam logic [1:0] CSR_PHASE_TICKS = 2'd0;
   localparam logic [1:0] CSR_HOME_POS    = 2'd1;
   localparam logic [1:0] CSR_LEFT_LIMIT  = 2'd2;
   localparam logic [1:0] CSR_RIGHT_LIMIT = 2'd3;

   localparam logic [15:0] PHASE_TICKS_RST = 16'd10;
   localparam logic [15:0] HOME_POS_RST    = 16'h0000;
   localparam logic [15:0] LEFT_LIMIT_RST  = 16'h8000;
   localparam logic [15:0] RIGHT_LIMIT_RST = 16'h7FFF;

   typedef struct packed {
      logic [3:0]         coils;
      logic signed [15:0] position;
      logic               busy_res;
      logic               safe_ok;
   } rsp_type;

   function automatic logic [3:0] seq_cw(input logic [2:0] idx);
      logic [3:0] pat;
      case (idx)
         3'd0: pat = 4'b1000;
         3'd1: pat = 4'b1100;
         3'd2: pat = 4'b0100;
         3'd3: pat = 4'b0110;
         3'd4: pat = 4'b0010;
         3'd5: pat = 4'b0011;
         3'd6: pat = 4'b0001;
         default: pat = 4'b1001;
      endcase
      return pat;
   endfunction

   function automatic logic [3:0] seq_ccw(input logic [2:0] idx);
      logic [3:0] pat;
      case (idx)
         3'd0: pat = 4'b0001;
         3'd1: pat = 4'b0011;
         3'd2: pat = 4'b0010;
         3'd3: pat = 4'b0110;
         3'd4: pat = 4'b0100;
         3'd5: pat = 4'b1100;
         3'd6: pat = 4'b1000;
         default: pat = 4'b1001;
      endcase
      return pat;
   endfunction

endpackage

>>> rtl/shp_if.sv
// Valid/ready channel interfaces for command items and result items.
// No dependencies.
interface shp_req_if;
   logic               valid;
   logic               ready;
   logic [2:0]         func;
   logic signed [15:0] target;
   logic               direction;

   modport source (output valid, output func, output target, output direction, input ready);
   modport sink (input valid, input func, input target, input direction, output ready);
endinterface

interface shp_rsp_if;
   logic               valid;
   logic               ready;
   logic [3:0]         coils;
   logic signed [15:0] position;
   logic               busy_res;
   logic               safe_ok;

   modport source (output valid, output coils, output position, output busy_res,
                   output safe_ok, input ready);
   modport sink (input valid, input coils, input position, input busy_res,
                 input safe_ok, output ready);
endinterface

>>> rtl/shp_core.sv
// Positioner state: csr_we-written registers, position, goal, phase and hold count.
// Motion state updates in the cycle an item is accepted. Depends on shp_pkg.
module shp_core import shp_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_we,
   input  logic [1:0]         csr_index,
   input  logic [15:0]        csr_wdata,
   input  logic               accept,
   input  logic [2:0]         func,
   input  logic signed [15:0] target,
   input  logic               direction,
   output rsp_type            result
);

   logic [15:0]        phase_ticks_ff;
   logic signed [15:0] home_ff, left_ff, right_ff;

   logic signed [15:0] pos_ff, pos_in;
   logic signed [15:0] goal_ff, goal_in;
   logic [2:0]         phase_ff, phase_in;
   logic [15:0]        hold_ff, hold_in;
   logic               moving_ff, moving_in;
   logic               cw_ff, cw_in;
   logic [3:0]         coil_ff, coil_in;

   logic [15:0]        limit;
   logic [15:0]        hold_inc;
   logic [2:0]         phase_inc;
   logic signed [15:0] pos_step;
   logic signed [15:0] new_goal;
   logic signed [16:0] pos_wide;
   logic               ok;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ticks_ff <= PHASE_TICKS_RST;
         home_ff        <= HOME_POS_RST;
         left_ff        <= LEFT_LIMIT_RST;
         right_ff       <= RIGHT_LIMIT_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_PHASE_TICKS: phase_ticks_ff <= csr_wdata;
            CSR_HOME_POS:    home_ff        <= csr_wdata;
            CSR_LEFT_LIMIT:  left_ff        <= csr_wdata;
            CSR_RIGHT_LIMIT: right_ff       <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      limit     = (phase_ticks_ff == 16'd0) ? 16'd1 : phase_ticks_ff;
      hold_inc  = hold_ff + 16'd1;
      phase_inc = phase_ff + 3'd1;
      pos_step  = cw_ff ? pos_ff + 16'sd1 : pos_ff - 16'sd1;
      new_goal  = (func == FUNC_CENTER) ? home_ff : target;
      pos_wide  = {pos_ff[15], pos_ff};

      pos_in    = pos_ff;
      goal_in   = goal_ff;
      phase_in  = phase_ff;
      hold_in   = hold_ff;
      moving_in = moving_ff;
      cw_in     = cw_ff;
      coil_in   = coil_ff;
      ok        = 1'b0;

      case (func)
         FUNC_TICK: begin
            if (moving_ff) begin
               coil_in = cw_ff ? seq_cw(phase_ff) : seq_ccw(phase_ff);
               hold_in = hold_inc;
               if (hold_inc >= limit) begin
                  hold_in  = 16'd0;
                  phase_in = phase_inc;
                  // full cycle done: step position one toward the goal
                  if (phase_inc == 3'd0) begin
                     pos_in = pos_step;
                     if (pos_step == goal_ff)
                        moving_in = 1'b0;
                     else
                        cw_in = pos_step < goal_ff;
                  end
               end
            end
         end
         FUNC_MOVE, FUNC_CENTER: begin
            goal_in  = new_goal;
            phase_in = 3'd0;
            hold_in  = 16'd0;
            if (pos_ff == new_goal) begin
               moving_in = 1'b0;
            end else begin
               moving_in = 1'b1;
               cw_in     = pos_ff < new_goal;
            end
         end
         FUNC_QUERY: begin
            if (direction)
               ok = !((pos_wide + 17'sd1) > $signed({right_ff[15], right_ff}));
            else
               ok = !((pos_wide - 17'sd1) < $signed({left_ff[15], left_ff}));
         end
         FUNC_LOAD: begin
            pos_in    = target;
            goal_in   = target;
            moving_in = 1'b0;
            phase_in  = 3'd0;
            hold_in   = 16'd0;
         end
         default: ;
      endcase

      result.coils    = coil_in;
      result.position = pos_in;
      result.busy_res = moving_in;
      result.safe_ok  = ok;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         goal_ff   <= '0;
         phase_ff  <= '0;
         hold_ff   <= '0;
         moving_ff <= 1'b0;
         cw_ff     <= 1'b0;
         coil_ff   <= '0;
      end else if (accept) begin
         pos_ff    <= pos_in;
         goal_ff   <= goal_in;
         phase_ff  <= phase_in;
         hold_ff   <= hold_in;
         moving_ff <= moving_in;
         cw_ff     <= cw_in;
         coil_ff   <= coil_in;
      end
   end

endmodule

>>> rtl/shp_outbuf.sv
// Result register with a skid stage behind it, so a new item is taken while a
// result waits. Depends on shp_pkg.
module shp_outbuf import shp_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  rsp_type in_data,
   output logic    out_valid,
   input  logic    out_ready,
   output rsp_type out_data
);

   logic    out_valid_ff, out_valid_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type out_data_ff, out_data_in;
   rsp_type skid_data_ff, skid_data_in;
   logic    take, acc;

   assign in_ready  = !skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;
   assign take      = out_valid_ff && out_ready;
   assign acc       = in_valid && !skid_valid_ff;

   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_data_in   = out_data_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         if (take) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (acc) begin
         if (!out_valid_ff || take) begin
            out_data_in  = in_data;
            out_valid_in = 1'b1;
         end else begin
            skid_data_in  = in_data;
            skid_valid_in = 1'b1;
         end
      end else if (take) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

endmodule

>>> rtl/stepper_half_step_positioner.sv
// Top level of the half-step stepper positioner.
// Depends on shp_pkg, shp_if, shp_core and shp_outbuf.
//
// Usage:
//   req_chan carries command items (func, target, direction): tick, move,
//   center, safe query and load. rsp_chan returns exactly one result item per
//   command: coil pattern, position, busy flag and safe query answer, all
//   taken after the command has been applied.
//   csr_we/csr_index/csr_wdata write phase_ticks, home_position, left_limit
//   and right_limit; write them only while no item is in flight.
// Timing:
//   One item per clock while req_chan.ready is high. All state updates in the cycle
//   the item is accepted; its result is registered in the result register, offered
//   on rsp_chan and held there until taken.
//   When the receiver stalls, one more item is taken into a skid register;
//   after that req_chan.ready drops until the result register drains.
// Reset:
//   Synchronous, active high. Position, goal, phase and hold count clear,
//   coils are off, no motion, registers return to their reset values and both
//   output stages are emptied.
module stepper_half_step_positioner import shp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   shp_req_if.sink     req_chan,
   shp_rsp_if.source   rsp_chan,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   rsp_type result, rsp_data;
   logic    accept;

   assign accept = req_chan.valid && req_chan.ready;

   shp_core u_core (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .accept    (accept),
      .func      (req_chan.func),
      .target    (req_chan.target),
      .direction (req_chan.direction),
      .result    (result)
   );

   shp_outbuf u_outbuf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_chan.valid),
      .in_ready  (req_chan.ready),
      .in_data   (result),
      .out_valid (rsp_chan.valid),
      .out_ready (rsp_chan.ready),
      .out_data  (rsp_data)
   );

   assign rsp_chan.coils    = rsp_data.coils;
   assign rsp_chan.position = rsp_data.position;
   assign rsp_chan.busy_res = rsp_data.busy_res;
   assign rsp_chan.safe_ok  = rsp_data.safe_ok;

endmodule

>>> rtl/shp_checker.sv
// Port-level checks for the stepper positioner, bound to the top level.
// Depends on stepper_half_step_positioner and its channel interfaces.
module shp_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [3:0] rsp_coils
);

   // a stalled result stays offered
   ast_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result item dropped while stalled");

   // with no result pending, an accepted item shows up next cycle
   ast_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !rsp_valid |=> rsp_valid)
      else $error("result item missing one cycle after accept");

   // input only backs up when the result register is full
   ast_ready: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("input stalled with empty result register");

   ast_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("output stages not empty after reset");

   ast_coils: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_coils == 4'b0000 || rsp_coils == 4'b1000 ||
                     rsp_coils == 4'b1100 || rsp_coils == 4'b0100 ||
                     rsp_coils == 4'b0110 || rsp_coils == 4'b0010 ||
                     rsp_coils == 4'b0011 || rsp_coils == 4'b0001 ||
                     rsp_coils == 4'b1001))
      else $error("illegal coil pattern");

endmodule

bind stepper_half_step_positioner shp_checker u_shp_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_coils (rsp_chan.coils)
);

>>> tb/stepper_half_step_positioner_tb.sv
// Self-checking testbench for stepper_half_step_positioner: a cycle-free predictor
// checks every result item against what the command stream should produce.
// Depends on shp_pkg, shp_if and the RTL under rtl/.
module stepper_half_step_positioner_tb;
   import shp_pkg::*;

   localparam int HALF_PERIOD   = 10;
   localparam int DRAIN_CYCLES  = 4;
   localparam int STALL_STRETCH = 60;
   localparam int MAX_REPORTS   = 10;

   localparam logic [2:0] FUNC_SPARE_LO = 3'd5;
   localparam logic [2:0] FUNC_SPARE_HI = 3'd7;

   // coil patterns packed 4 bits per phase, phase 0 in the low nibble
   localparam logic [31:0] CW_COILS  = 32'h9132_64C8;
   localparam logic [31:0] CCW_COILS = 32'h98C4_6231;

   logic clock = 1'b0;
   logic reset = 1'b1;

   always #(HALF_PERIOD) clock = ~clock;

   shp_req_if req_if ();
   shp_rsp_if rsp_if ();

   logic        csr_we;
   logic [1:0]  csr_index;
   logic [15:0] csr_wdata;

   stepper_half_step_positioner dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_if),
      .rsp_chan  (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // predictor copy of registers and motion state
   logic [15:0]        hold_ticks;
   logic signed [15:0] home_pos;
   logic signed [15:0] left_lim;
   logic signed [15:0] right_lim;
   logic signed [15:0] pos;
   logic signed [15:0] goal;
   logic [2:0]         phase;
   logic [15:0]        hold_cnt;
   logic               running;
   logic               cw;
   logic [3:0]         coil;

   rsp_type expected_q[$];
   rsp_type want;

   int send_idle_pct;
   int recv_stall_pct;
   int hold_left;
   int n_sent;
   int n_checked;
   int n_errors;
   int n_steps;
   int n_settings;

   function automatic void clear_positioner();
      hold_ticks = PHASE_TICKS_RST;
      home_pos   = HOME_POS_RST;
      left_lim   = LEFT_LIMIT_RST;
      right_lim  = RIGHT_LIMIT_RST;
      pos        = '0;
      goal       = '0;
      phase      = '0;
      hold_cnt   = '0;
      running    = 1'b0;
      cw         = 1'b0;
      coil       = '0;
   endfunction

   function automatic void aim_at(logic signed [15:0] g);
      goal     = g;
      phase    = '0;
      hold_cnt = '0;
      if (pos == g) begin
         running = 1'b0;
      end else begin
         running = 1'b1;
         cw      = pos < g;
      end
   endfunction

   function automatic void advance_tick();
      logic [15:0] lim;
      if (!running) return;
      coil = cw ? CW_COILS[{phase, 2'b00} +: 4] : CCW_COILS[{phase, 2'b00} +: 4];
      lim = (hold_ticks == 16'd0) ? 16'd1 : hold_ticks;
      hold_cnt = hold_cnt + 16'd1;
      if (hold_cnt < lim) return;
      hold_cnt = '0;
      phase = phase + 3'd1;
      if (phase != 3'd0) return;
      pos = cw ? pos + 16'sd1 : pos - 16'sd1;
      n_steps++;
      if (pos == goal) running = 1'b0;
      else cw = pos < goal;
   endfunction

   function automatic rsp_type predict_result(logic [2:0] f, logic signed [15:0] t, logic d);
      rsp_type r;
      int      p;
      p = int'(pos);
      r.safe_ok = 1'b0;
      case (f)
         FUNC_TICK:   advance_tick();
         FUNC_MOVE:   aim_at(t);
         FUNC_CENTER: aim_at(home_pos);
         FUNC_QUERY:  r.safe_ok = d ? (p + 1 <= int'(right_lim)) : (p - 1 >= int'(left_lim));
         FUNC_LOAD: begin
            pos      = t;
            goal     = t;
            running  = 1'b0;
            phase    = '0;
            hold_cnt = '0;
         end
         default: ;
      endcase
      r.coils    = coil;
      r.position = pos;
      r.busy_res = running;
      return r;
   endfunction

   // result side: random stalls, plus a long hold-off counted down here
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_if.ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else begin
         rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_q.size() == 0) begin
            n_errors++;
            if (n_errors <= MAX_REPORTS)
               $display("unexpected result item: coils %b position %0d busy %b safe %b",
                        rsp_if.coils, rsp_if.position, rsp_if.busy_res, rsp_if.safe_ok);
         end else begin
            want = expected_q.pop_front();
            n_checked++;
            if (rsp_if.coils !== want.coils || rsp_if.position !== want.position ||
                rsp_if.busy_res !== want.busy_res || rsp_if.safe_ok !== want.safe_ok) begin
               n_errors++;
               if (n_errors <= MAX_REPORTS)
                  $display({"result %0d mismatch: expected coils %b pos %0d busy %b safe %b,",
                            " got coils %b pos %0d busy %b safe %b"},
                           n_checked, want.coils, want.position, want.busy_res,
                           want.safe_ok, rsp_if.coils, rsp_if.position, rsp_if.busy_res,
                           rsp_if.safe_ok);
            end
         end
      end
   end

   task automatic send_cmd(logic [2:0] f, logic signed [15:0] t, logic d);
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid     <= 1'b1;
      req_if.func      <= f;
      req_if.target    <= t;
      req_if.direction <= d;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      expected_q.push_back(predict_result(f, t, d));
      n_sent++;
   endtask

   task automatic wait_idle();
      req_if.valid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [15:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_PHASE_TICKS: hold_ticks = val;
         CSR_HOME_POS:    home_pos   = val;
         CSR_LEFT_LIMIT:  left_lim   = val;
         CSR_RIGHT_LIMIT: right_lim  = val;
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic configure(logic [15:0] ticks, logic signed [15:0] home,
                            logic signed [15:0] left, logic signed [15:0] right);
      wait_idle();
      write_reg(CSR_PHASE_TICKS, ticks);
      write_reg(CSR_HOME_POS, home);
      write_reg(CSR_LEFT_LIMIT, left);
      write_reg(CSR_RIGHT_LIMIT, right);
      n_settings++;
   endtask

   // mostly ticks so moves run to completion; most targets stay near the current
   // position and most loads near the limits or home, so queries hit their edges
   task automatic random_items(int n);
      int                 counted;
      int                 r;
      logic [2:0]         f;
      logic signed [15:0] t;
      logic               d;
      counted = 0;
      while (counted < n) begin
         r = $urandom_range(99);
         t = 16'($urandom);
         d = 1'($urandom_range(1));
         if (r < 64) begin
            f = FUNC_TICK;
         end else if (r < 74) begin
            f = FUNC_MOVE;
            if ($urandom_range(9) != 0)
               t = 16'(int'(pos) + int'($urandom_range(8)) - 4);
         end else if (r < 78) begin
            f = FUNC_CENTER;
         end else if (r < 88) begin
            f = FUNC_QUERY;
         end else if (r < 95) begin
            f = FUNC_LOAD;
            case ($urandom_range(4))
               0: t = 16'(int'(left_lim) + int'($urandom_range(2)) - 1);
               1: t = 16'(int'(right_lim) + int'($urandom_range(2)) - 1);
               2: t = 16'(int'(home_pos) + int'($urandom_range(6)) - 3);
               3: t = 16'(int'($urandom_range(16)) - 8);
               default: ;
            endcase
         end else begin
            f = FUNC_SPARE_LO + 3'($urandom_range(2));
         end
         send_cmd(f, t, d);
         if (f <= FUNC_LOAD) counted++;
      end
   endtask

   task automatic test_idle_and_spare();
      send_cmd(FUNC_TICK, 16'sd0, 1'b0);
      for (int i = 0; i <= FUNC_SPARE_HI - FUNC_SPARE_LO; i++)
         send_cmd(FUNC_SPARE_LO + 3'(i), 16'($urandom), 1'($urandom_range(1)));
      send_cmd(FUNC_QUERY, 16'sd0, 1'b0);
      send_cmd(FUNC_QUERY, 16'sd0, 1'b1);
   endtask

   // queries at the ends of the 16-bit range must not overflow
   task automatic test_range_ends();
      send_cmd(FUNC_LOAD, 16'sh7FFF, 1'b0);
      send_cmd(FUNC_QUERY, 16'sd0, 1'b1);
      send_cmd(FUNC_QUERY, 16'sd0, 1'b0);
      send_cmd(FUNC_LOAD, -16'sh8000, 1'b1);
      send_cmd(FUNC_QUERY, 16'sd0, 1'b0);
      send_cmd(FUNC_QUERY, 16'sd0, 1'b1);
   endtask

   task automatic test_full_cycle();
      // zero hold time acts as one tick per phase
      configure(16'd0, -16'sd1, LEFT_LIMIT_RST, RIGHT_LIMIT_RST);
      send_cmd(FUNC_LOAD, 16'sh7FFE, 1'b0);
      send_cmd(FUNC_MOVE, 16'sh7FFF, 1'b0);
      repeat (8) send_cmd(FUNC_TICK, 16'($urandom), 1'($urandom_range(1)));
      send_cmd(FUNC_TICK, 16'sd0, 1'b0);
      send_cmd(FUNC_MOVE, 16'sh7FFF, 1'b1);
      send_cmd(FUNC_CENTER, 16'sd0, 1'b0);
      repeat (3) send_cmd(FUNC_TICK, 16'sd0, 1'b0);
      // new goal equal to position stops mid-cycle
      send_cmd(FUNC_MOVE, 16'sh7FFF, 1'b0);
      send_cmd(FUNC_CENTER, 16'sd0, 1'b0);
      send_cmd(FUNC_TICK, 16'sd0, 1'b0);
      send_cmd(FUNC_LOAD, 16'sd5, 1'b0);
      send_cmd(FUNC_TICK, 16'sd0, 1'b0);
   endtask

   task automatic run_phase(int idle, int stall, logic [15:0] ticks, logic signed [15:0] home,
                            logic signed [15:0] left, logic signed [15:0] right, int n);
      configure(ticks, home, left, right);
      send_idle_pct  = idle;
      recv_stall_pct = stall;
      random_items(n);
   endtask

   task automatic test_backpressure();
      configure(16'd3, 16'sh7FFF, 16'sd0, 16'sd0);
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      hold_left <= STALL_STRETCH;
      random_items(24);
   endtask

   initial begin
      req_if.valid     = 1'b0;
      req_if.func      = FUNC_TICK;
      req_if.target    = '0;
      req_if.direction = 1'b0;
      rsp_if.ready     = 1'b0;
      csr_we           = 1'b0;
      csr_index        = CSR_PHASE_TICKS;
      csr_wdata        = '0;
      hold_left        = 0;
      send_idle_pct    = 0;
      recv_stall_pct   = 0;
      n_sent           = 0;
      n_checked        = 0;
      n_errors         = 0;
      n_steps          = 0;
      n_settings       = 0;
      clear_positioner();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_idle_and_spare();
      test_range_ends();
      test_full_cycle();
      run_phase(0, 0, 16'd1, 16'sd2, -16'sd5, 16'sd5, 220);
      run_phase(70, 0, 16'd2, -16'sh8000, -16'sh8000, 16'sh7FFF, 220);
      test_backpressure();
      run_phase(0, 70, 16'd3, 16'sh7FFF, 16'sd0, 16'sd0, 200);
      run_phase(15, 15, 16'd0, -16'sd3, -16'sd10, 16'sd10, 220);
      run_phase(15, 15, 16'hFFFF, 16'sd1, -16'sd2, 16'sd3, 20);
      wait_idle();

      $display("Sent %0d items, checked %0d results, %0d whole coil cycles stepped",
               n_sent, n_checked, n_steps);
      $display("Covered %0d register settings, four idle mixes and one long result hold-off",
               n_settings);
      if (n_errors == 0 && expected_q.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   initial begin
      #(4_000_000);
      $display("timeout with %0d results outstanding", expected_q.size());
      $display("FAIL");
      $finish;
   end

endmodule
